// ----- rtl/lrce_pkg.sv -----
package lrce_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_YELLOW_REFERENCE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WHITE_REFERENCE     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HUE_TOLERANCE       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SATURATION_TOLERANCE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_VALUE_TOLERANCE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LANE_SPAN           = 3'd5;

  // Register values after reset.
  localparam logic [23:0] YELLOW_REFERENCE_RESET     = 24'h1EECFF;
  localparam logic [23:0] WHITE_REFERENCE_RESET      = 24'h0000FF;
  localparam logic [7:0]  HUE_TOLERANCE_RESET        = 8'd3;
  localparam logic [7:0]  SATURATION_TOLERANCE_RESET = 8'd30;
  localparam logic [7:0]  VALUE_TOLERANCE_RESET      = 8'd30;
  localparam logic [7:0]  LANE_SPAN_RESET            = 8'd75;

  // Lane case codes.
  localparam logic [1:0] LANE_NONE   = 2'd0;
  localparam logic [1:0] LANE_BOTH   = 2'd1;
  localparam logic [1:0] LANE_WHITE  = 2'd2;
  localparam logic [1:0] LANE_YELLOW = 2'd3;

  // Row record queue between the pixel front and the division back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic       row_end;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [6:0]         row_number;
    logic signed [11:0] center_column;
    logic [1:0]         lane_case;
    logic [10:0]        yellow_matches;
    logic [10:0]        white_matches;
  } result_t;

  typedef struct packed {
    logic [23:0] yellow_reference;
    logic [23:0] white_reference;
    logic [7:0]  hue_tolerance;
    logic [7:0]  saturation_tolerance;
    logic [7:0]  value_tolerance;
    logic [7:0]  lane_span;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIVIDE,
    BACK_EMIT
  } back_state_t;

endpackage

// ----- rtl/lrce_front.sv -----
module lrce_front #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 128,
  localparam int unsigned COL_W = $clog2(MAX_COLUMNS + 1),
  localparam int unsigned CNT_W = COL_W,
  localparam int unsigned SUM_W = $clog2(MAX_COLUMNS * (MAX_COLUMNS - 1) / 2 + 1),
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned ADD_W = (SUM_W > COL_W) ? SUM_W : COL_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  lrce_pkg::pixel_t               pixel,
  input  lrce_pkg::cfg_regs_t            cfg,
  output logic                           row_push,
  output logic [ROW_W-1:0]               row_number,
  output logic [SUM_W-1:0]               yellow_sum,
  output logic [SUM_W-1:0]               white_sum,
  output logic [CNT_W-1:0]               yellow_count,
  output logic [CNT_W-1:0]               white_count
);

  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic [SUM_W-1:0] ysum;
  logic [SUM_W-1:0] wsum;
  logic [CNT_W-1:0] ycnt;
  logic [CNT_W-1:0] wcnt;

  logic             in_range;
  logic             yellow_hit;
  logic             white_hit;
  logic             row_done;
  logic [ADD_W-1:0] ysum_add;
  logic [ADD_W-1:0] wsum_add;
  logic [ROW_W:0]   row_inc;

  // Open window test: center - tol < c < center + tol, done without wrap.
  function automatic logic channel_inside(input logic [7:0] c, input logic [7:0] center_v,
                                          input logic [7:0] tol);
    logic [8:0] c_plus;
    logic [8:0] center_plus;
    c_plus      = {1'b0, c} + {1'b0, tol};
    center_plus = {1'b0, center_v} + {1'b0, tol};
    return (c_plus > {1'b0, center_v}) && ({1'b0, c} < center_plus);
  endfunction

  function automatic logic colour_match(input lrce_pkg::pixel_t p, input logic [23:0] center_v,
                                        input lrce_pkg::cfg_regs_t c);
    return channel_inside(p.hue, center_v[23:16], c.hue_tolerance)
        && channel_inside(p.saturation, center_v[15:8], c.saturation_tolerance)
        && channel_inside(p.brightness, center_v[7:0], c.value_tolerance);
  endfunction

  always_comb begin
    in_range   = column < COL_W'(MAX_COLUMNS);
    yellow_hit = in_range && colour_match(pixel, cfg.yellow_reference, cfg);
    white_hit  = in_range && colour_match(pixel, cfg.white_reference, cfg);
    row_done   = accept && (pixel.row_end || pixel.frame_end);
    ysum_add   = ADD_W'(ysum) + ADD_W'(column);
    wsum_add   = ADD_W'(wsum) + ADD_W'(column);
    row_inc    = {1'b0, row} + 1'b1;

    yellow_sum   = yellow_hit ? ysum_add[SUM_W-1:0] : ysum;
    white_sum    = white_hit ? wsum_add[SUM_W-1:0] : wsum;
    yellow_count = yellow_hit ? ycnt + 1'b1 : ycnt;
    white_count  = white_hit ? wcnt + 1'b1 : wcnt;
    row_number   = row;
    row_push     = row_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
      ysum   <= '0;
      wsum   <= '0;
      ycnt   <= '0;
      wcnt   <= '0;
    end else if (accept) begin
      if (row_done) begin
        column <= '0;
        ysum   <= '0;
        wsum   <= '0;
        ycnt   <= '0;
        wcnt   <= '0;
        if (pixel.frame_end || (row_inc >= (ROW_W + 1)'(MAX_ROWS))) begin
          row <= '0;
        end else begin
          row <= row_inc[ROW_W-1:0];
        end
      end else begin
        if (in_range) begin
          column <= column + 1'b1;
        end
        ysum <= yellow_sum;
        wsum <= white_sum;
        ycnt <= yellow_count;
        wcnt <= white_count;
      end
    end
  end

endmodule

// ----- rtl/lrce_queue.sv -----
module lrce_queue #(
  parameter int unsigned WIDTH = 72
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0]                  entries [lrce_pkg::QUEUE_DEPTH];
  logic [lrce_pkg::QUEUE_PTR_W-1:0]  wr_ptr;
  logic [lrce_pkg::QUEUE_PTR_W-1:0]  rd_ptr;
  logic [lrce_pkg::QUEUE_PTR_W:0]    count;

  assign full  = count == (lrce_pkg::QUEUE_PTR_W + 1)'(lrce_pkg::QUEUE_DEPTH);
  assign empty = count == '0;
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("row queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("row queue read while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 1'b1)
    else $error("row queue count did not follow a write");

endmodule

// ----- rtl/lrce_back.sv -----
module lrce_back #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 128,
  localparam int unsigned COL_W  = $clog2(MAX_COLUMNS + 1),
  localparam int unsigned CNT_W  = COL_W,
  localparam int unsigned SUM_W  = $clog2(MAX_COLUMNS * (MAX_COLUMNS - 1) / 2 + 1),
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int unsigned MEAN_W = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1,
  localparam int unsigned ITER_W = $clog2(SUM_W + 1),
  localparam int unsigned CTR_A  = ((MEAN_W > 8) ? MEAN_W : 8) + 2,
  localparam int unsigned CTR_W  = (CTR_A > 12) ? CTR_A : 12,
  localparam int unsigned ROWX_W = (ROW_W > 7) ? ROW_W : 7,
  localparam int unsigned CNTX_W = (CNT_W > 11) ? CNT_W : 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  logic [ROW_W-1:0]    q_row_number,
  input  logic [SUM_W-1:0]    q_yellow_sum,
  input  logic [SUM_W-1:0]    q_white_sum,
  input  logic [CNT_W-1:0]    q_yellow_count,
  input  logic [CNT_W-1:0]    q_white_count,
  output logic                q_pop,
  input  logic [7:0]          lane_span,
  output lrce_pkg::result_t   result,
  output logic                empty,
  input  logic                pop
);

  lrce_pkg::back_state_t state;
  lrce_pkg::back_state_t state_next;

  logic [ITER_W-1:0] iter;
  logic [SUM_W-1:0]  yquot;
  logic [SUM_W-1:0]  wquot;
  logic [CNT_W-1:0]  yrem;
  logic [CNT_W-1:0]  wrem;
  logic [CNT_W-1:0]  ydiv;
  logic [CNT_W-1:0]  wdiv;
  logic [ROW_W-1:0]  row;
  logic              out_valid;
  lrce_pkg::result_t out_reg;

  logic              load;
  logic              step;
  logic              emit;
  logic [CNT_W:0]    yshift;
  logic [CNT_W:0]    wshift;
  logic [CNT_W:0]    ysub;
  logic [CNT_W:0]    wsub;
  logic              yge;
  logic              wge;
  logic [CTR_W-1:0]  ymean;
  logic [CTR_W-1:0]  wmean;
  logic [CTR_W-1:0]  half;
  logic [CTR_W-1:0]  mid_sum;
  logic [CTR_W-1:0]  center;
  logic [1:0]        lane_case;
  logic [ROWX_W-1:0] row_x;
  logic [CNTX_W-1:0] ycnt_x;
  logic [CNTX_W-1:0] wcnt_x;

  // One restoring step for both dividers: shift the next dividend bit into the
  // remainder and subtract the match count when it fits.
  always_comb begin
    yshift = {yrem, yquot[SUM_W-1]};
    wshift = {wrem, wquot[SUM_W-1]};
    yge    = yshift >= {1'b0, ydiv};
    wge    = wshift >= {1'b0, wdiv};
    ysub   = yshift - {1'b0, ydiv};
    wsub   = wshift - {1'b0, wdiv};
  end

  always_comb begin
    ymean   = CTR_W'(yquot[MEAN_W-1:0]);
    wmean   = CTR_W'(wquot[MEAN_W-1:0]);
    half    = CTR_W'(lane_span[7:1]);
    mid_sum = ymean + wmean;
    if ((ydiv != '0) && (wdiv != '0)) begin
      center    = {1'b0, mid_sum[CTR_W-1:1]};
      lane_case = lrce_pkg::LANE_BOTH;
    end else if (wdiv != '0) begin
      center    = wmean - half;
      lane_case = lrce_pkg::LANE_WHITE;
    end else if (ydiv != '0) begin
      center    = ymean + half;
      lane_case = lrce_pkg::LANE_YELLOW;
    end else begin
      center    = '0;
      lane_case = lrce_pkg::LANE_NONE;
    end
    row_x  = ROWX_W'(row);
    ycnt_x = CNTX_W'(ydiv);
    wcnt_x = CNTX_W'(wdiv);
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    step       = 1'b0;
    emit       = 1'b0;
    case (state)
      lrce_pkg::BACK_IDLE: begin
        if (!q_empty) begin
          load       = 1'b1;
          state_next = lrce_pkg::BACK_DIVIDE;
        end
      end
      lrce_pkg::BACK_DIVIDE: begin
        step = 1'b1;
        if (iter == ITER_W'(SUM_W - 1)) begin
          state_next = lrce_pkg::BACK_EMIT;
        end
      end
      lrce_pkg::BACK_EMIT: begin
        if (!out_valid || pop) begin
          emit       = 1'b1;
          state_next = lrce_pkg::BACK_IDLE;
        end
      end
      default: begin
        state_next = lrce_pkg::BACK_IDLE;
      end
    endcase
  end

  assign q_pop  = load;
  assign empty  = !out_valid;
  assign result = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrce_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      iter  <= '0;
      yquot <= q_yellow_sum;
      wquot <= q_white_sum;
      yrem  <= '0;
      wrem  <= '0;
      ydiv  <= q_yellow_count;
      wdiv  <= q_white_count;
      row   <= q_row_number;
    end else if (step) begin
      iter  <= iter + 1'b1;
      yquot <= SUM_W'({yquot, yge});
      wquot <= SUM_W'({wquot, wge});
      yrem  <= yge ? ysub[CNT_W-1:0] : yshift[CNT_W-1:0];
      wrem  <= wge ? wsub[CNT_W-1:0] : wshift[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg.row_number     <= row_x[6:0];
      out_reg.center_column  <= center[11:0];
      out_reg.lane_case      <= lane_case;
      out_reg.yellow_matches <= ycnt_x[10:0];
      out_reg.white_matches  <= wcnt_x[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
      state == lrce_pkg::BACK_DIVIDE |-> iter < ITER_W'(SUM_W))
    else $error("divider ran past its last step");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
      q_pop |-> state == lrce_pkg::BACK_IDLE && !q_empty)
    else $error("row record taken outside idle");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
      out_valid && !pop |=> out_valid && $stable(out_reg))
    else $error("waiting result was lost or overwritten");

endmodule

// ----- rtl/lane_row_center_extractor.sv -----
// A row's totals pass through the row queue and the back's idle, divide and emit states to the
// result ports, and are held in the emit state while an earlier result has not been popped.
// Throughput: one pixel per cycle while full is low. The shared pair of dividers takes one row
// at a time, so a run of short rows fills the four-entry row queue and full rises until it drains.
// Reset (rst, synchronous): counters and row queue are cleared, the back returns to idle,
// the result is marked empty and the configuration registers return to their reset values.
module lane_row_center_extractor #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  // Pixel side.
  input  logic                                push,
  output logic                                full,
  input  lrce_pkg::pixel_t                    pixel,
  // Result side.
  output logic                                empty,
  input  logic                                pop,
  output lrce_pkg::result_t                   result,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrce_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lrce_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Widths that follow from the frame geometry. A column counter must be able to hold
  // MAX_COLUMNS itself, because it parks there when a row runs too long.
  localparam int unsigned COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CNT_W = COL_W;
  localparam int unsigned SUM_W = $clog2(MAX_COLUMNS * (MAX_COLUMNS - 1) / 2 + 1);
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned REC_W = ROW_W + 2 * SUM_W + 2 * CNT_W;

  lrce_pkg::cfg_regs_t cfg;

  logic             accept;
  logic             row_push;
  logic [ROW_W-1:0] f_row;
  logic [SUM_W-1:0] f_ysum;
  logic [SUM_W-1:0] f_wsum;
  logic [CNT_W-1:0] f_ycnt;
  logic [CNT_W-1:0] f_wcnt;

  logic             q_pop;
  logic             q_empty;
  logic [REC_W-1:0] q_din;
  logic [REC_W-1:0] q_dout;
  logic [ROW_W-1:0] q_row;
  logic [SUM_W-1:0] q_ysum;
  logic [SUM_W-1:0] q_wsum;
  logic [CNT_W-1:0] q_ycnt;
  logic [CNT_W-1:0] q_wcnt;

  // The configuration port never stalls. Writes are expected only while the block
  // is idle, so the live register values feed both halves directly.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.yellow_reference     <= lrce_pkg::YELLOW_REFERENCE_RESET;
      cfg.white_reference      <= lrce_pkg::WHITE_REFERENCE_RESET;
      cfg.hue_tolerance        <= lrce_pkg::HUE_TOLERANCE_RESET;
      cfg.saturation_tolerance <= lrce_pkg::SATURATION_TOLERANCE_RESET;
      cfg.value_tolerance      <= lrce_pkg::VALUE_TOLERANCE_RESET;
      cfg.lane_span            <= lrce_pkg::LANE_SPAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrce_pkg::REG_YELLOW_REFERENCE:     cfg.yellow_reference     <= cfg_data;
        lrce_pkg::REG_WHITE_REFERENCE:      cfg.white_reference      <= cfg_data;
        lrce_pkg::REG_HUE_TOLERANCE:        cfg.hue_tolerance        <= cfg_data[7:0];
        lrce_pkg::REG_SATURATION_TOLERANCE: cfg.saturation_tolerance <= cfg_data[7:0];
        lrce_pkg::REG_VALUE_TOLERANCE:      cfg.value_tolerance      <= cfg_data[7:0];
        lrce_pkg::REG_LANE_SPAN:            cfg.lane_span            <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // A pixel beat is taken whenever the row queue has room. The front classifies each
  // pixel against both colour windows and keeps the per-row match counts and column
  // sums; on the last pixel of a row it hands the finished totals to the queue.
  assign accept = push && !full;

  lrce_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel        (pixel),
    .cfg          (cfg),
    .row_push     (row_push),
    .row_number   (f_row),
    .yellow_sum   (f_ysum),
    .white_sum    (f_wsum),
    .yellow_count (f_ycnt),
    .white_count  (f_wcnt)
  );

  assign q_din = {f_row, f_ysum, f_wsum, f_ycnt, f_wcnt};
  assign {q_row, q_ysum, q_wsum, q_ycnt, q_wcnt} = q_dout;

  // The queue lets the next rows stream in while the back still divides an earlier one.
  lrce_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (row_push),
    .din   (q_din),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // The back turns sums into mean columns with two bit-serial dividers working side by
  // side, picks the lane case and the center estimate, and holds the result in an
  // output register until it is popped.
  lrce_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_row_number   (q_row),
    .q_yellow_sum   (q_ysum),
    .q_white_sum    (q_wsum),
    .q_yellow_count (q_ycnt),
    .q_white_count  (q_wcnt),
    .q_pop          (q_pop),
    .lane_span      (cfg.lane_span),
    .result         (result),
    .empty          (empty),
    .pop            (pop)
  );

endmodule
